/* src/chtr_pkg.sv */
// ----------------------------------------------------------------------------
// chtr_pkg
// Types, codes and constants shared by the clustered hash table blocks.
// ----------------------------------------------------------------------------
package chtr_pkg;

    typedef enum logic [1:0] {
        CMD_PROBE    = 2'd0,
        CMD_STORE    = 2'd1,
        CMD_HASHFULL = 2'd2,
        CMD_CLEAR    = 2'd3
    } cmd_t;

    typedef enum logic [3:0] {
        ST_INIT,
        ST_IDLE,
        ST_EVAL,
        ST_HF_SCAN,
        ST_HF_LAST,
        ST_HF_MUL,
        ST_HF_DIV,
        ST_HF_OUT,
        ST_CLEAR,
        ST_CLR_OUT
    } state_t;

    // one way of a cluster
    typedef struct packed {
        logic [15:0] tag;
        logic [15:0] move;
        logic [15:0] value;
        logic [15:0] eval;
        logic [7:0]  gen;
        logic [7:0]  depth;
    } entry_t;

    // fields of a probe or store request held for the update cycle
    typedef struct packed {
        logic              is_store;
        logic [15:0]       tag;
        logic [15:0]       value;
        logic [15:0]       eval;
        logic              pv;
        logic [1:0]        bound;
        logic signed [8:0] depth;
        logic [15:0]       move;
    } req_t;

    typedef struct packed {
        logic   hit;
        entry_t ent;
    } sel_out_t;

    localparam logic [8:0]  AGE_BIAS      = 9'd263;
    localparam logic [7:0]  AGE_MASK      = 8'hF8;
    localparam logic [7:0]  GEN_LOW_MASK  = 8'h07;
    localparam int          TAG_LSB       = 48;
    localparam int          HF_SCALE      = 1000;
    localparam logic [7:0]  DEPTH_MARGIN  = 8'd4;
    localparam logic [1:0]  BND_EXACT     = 2'd3;
    localparam logic        REG_GENERATION = 1'b0;

endpackage

/* src/chtr_if.sv */
// ----------------------------------------------------------------------------
// chtr_cmd_if / chtr_result_if
// Valid/ready channels for commands into and results out of the table.
// ----------------------------------------------------------------------------
interface chtr_cmd_if;
    logic              valid;
    logic              ready;
    logic [1:0]        command;
    logic [63:0]       key;
    logic signed [15:0] new_value;
    logic signed [15:0] new_eval;
    logic              new_pv;
    logic [1:0]        new_bound;
    logic signed [8:0] new_depth;
    logic [15:0]       new_move;

    modport source (
        output valid, command, key, new_value, new_eval, new_pv, new_bound,
               new_depth, new_move,
        input  ready
    );
    modport sink (
        input  valid, command, key, new_value, new_eval, new_pv, new_bound,
               new_depth, new_move,
        output ready
    );
endinterface

interface chtr_result_if;
    logic               valid;
    logic               ready;
    logic               hit;
    logic [15:0]        stored_move;
    logic signed [15:0] stored_value;
    logic signed [15:0] stored_eval;
    logic signed [8:0]  stored_depth;
    logic [1:0]         stored_bound;
    logic               stored_pv;
    logic [9:0]         permill_full;

    modport source (
        output valid, hit, stored_move, stored_value, stored_eval, stored_depth,
               stored_bound, stored_pv, permill_full,
        input  ready
    );
    modport sink (
        input  valid, hit, stored_move, stored_value, stored_eval, stored_depth,
               stored_bound, stored_pv, permill_full,
        output ready
    );
endinterface

/* src/chtr_mem.sv */
// ----------------------------------------------------------------------------
// chtr_mem
// Cluster memory: one row holds all ways of a cluster, registered read.
// ----------------------------------------------------------------------------
module chtr_mem
    import chtr_pkg::*;
#(
    parameter int ADDR_W = 16,
    parameter int WAYS   = 3
) (
    input  logic                  clk,
    input  logic                  rd_en,
    input  logic [ADDR_W-1:0]     rd_addr,
    output entry_t [WAYS-1:0]     rd_data,
    input  logic                  wr_en,
    input  logic [ADDR_W-1:0]     wr_addr,
    input  entry_t [WAYS-1:0]     wr_data
);

    localparam int DEPTH = 1 << ADDR_W;

    entry_t [WAYS-1:0] mem [DEPTH];
    entry_t [WAYS-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

/* src/chtr_way_sel.sv */
// ----------------------------------------------------------------------------
// chtr_way_sel
// Picks the way of a cluster for a request and builds the updated row.
// ----------------------------------------------------------------------------
module chtr_way_sel
    import chtr_pkg::*;
#(
    parameter int WAYS       = 3,
    parameter int DEPTH_BIAS = 7
) (
    input  entry_t [WAYS-1:0] row,
    input  req_t              req,
    input  logic [7:0]        gen8,
    output entry_t [WAYS-1:0] row_new,
    output sel_out_t          sel_out
);

    localparam int WAY_W = (WAYS > 1) ? $clog2(WAYS) : 1;

    logic [WAYS-1:0]          match;
    logic signed [9:0]        repl_val [WAYS];
    logic                     found;
    logic [WAY_W-1:0]         sel;
    entry_t                   old_ent;
    entry_t                   ref_ent;
    entry_t                   upd_ent;
    logic signed [9:0]        bd_raw;
    logic [7:0]               bd;
    logic                     new_tag;
    logic                     replace;

    // per-way match and replace value (depth minus age)
    always_comb
    begin
        logic [8:0] age9;
        for (int i = 0; i < WAYS; i++)
        begin
            match[i]    = (row[i].tag == 16'd0) || (row[i].tag == req.tag);
            age9        = 9'(AGE_BIAS + {1'b0, gen8} - {1'b0, row[i].gen});
            repl_val[i] = $signed({2'b00, row[i].depth})
                        - $signed({2'b00, age9[7:0] & AGE_MASK});
        end
    end

    // first empty or matching way, else the lowest replace value
    always_comb
    begin
        logic [WAY_W-1:0]  best;
        logic signed [9:0] best_val;
        found    = 1'b0;
        sel      = '0;
        best     = '0;
        best_val = repl_val[0];
        for (int i = 0; i < WAYS; i++)
        begin
            if (!found && match[i])
            begin
                found = 1'b1;
                sel   = WAY_W'(i);
            end
        end
        for (int i = 1; i < WAYS; i++)
        begin
            if (best_val > repl_val[i])
            begin
                best_val = repl_val[i];
                best     = WAY_W'(i);
            end
        end
        if (!found)
        begin
            sel = best;
        end
    end

    assign old_ent = row[sel];

    // saturate biased depth to a byte
    assign bd_raw = $signed({req.depth[8], req.depth}) + $signed(10'(DEPTH_BIAS));

    always_comb
    begin
        if (bd_raw < 10'sd0)
        begin
            bd = 8'd0;
        end
        else if (bd_raw > 10'sd255)
        begin
            bd = 8'hFF;
        end
        else
        begin
            bd = bd_raw[7:0];
        end
    end

    assign new_tag = (req.tag != old_ent.tag);
    assign replace = new_tag
                  || ($signed({2'b00, bd})
                      > ($signed({2'b00, old_ent.depth}) - $signed({2'b00, DEPTH_MARGIN})))
                  || (req.bound == BND_EXACT);

    always_comb
    begin
        ref_ent = old_ent;
        if (found)
        begin
            ref_ent.gen = gen8 | (old_ent.gen & GEN_LOW_MASK);
        end
        upd_ent = ref_ent;
        if (req.is_store)
        begin
            if ((req.move != 16'd0) || new_tag)
            begin
                upd_ent.move = req.move;
            end
            if (replace)
            begin
                upd_ent.tag   = req.tag;
                upd_ent.value = req.value;
                upd_ent.eval  = req.eval;
                upd_ent.gen   = gen8 | {5'd0, req.pv, req.bound};
                upd_ent.depth = bd;
            end
        end
    end

    always_comb
    begin
        row_new      = row;
        row_new[sel] = upd_ent;
    end

    assign sel_out.hit = found && (old_ent.tag != 16'd0);
    assign sel_out.ent = upd_ent;

endmodule

/* src/chtr_div.sv */
// ----------------------------------------------------------------------------
// chtr_div
// Scales a count by SCALE / DIVISOR with compares against multiples of the
// divisor; the quotient is registered, with done, in the cycle after start.
// ----------------------------------------------------------------------------
module chtr_div
#(
    parameter int DIVISOR    = 999,
    parameter int SCALE      = 1000,
    parameter int DIVIDEND_W = 10,
    parameter int QUOT_W     = 10
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  start,
    input  logic [DIVIDEND_W-1:0] dividend,
    output logic                  done,
    output logic [QUOT_W-1:0]     quotient
);

    // n * SCALE / DIVISOR = n + n * EXCESS / DIVISOR, second term at most EXCESS
    localparam int EXCESS = SCALE - DIVISOR;
    localparam int PART_W = DIVIDEND_W + 4;

    logic [QUOT_W-1:0] quot_reg;
    logic              done_reg;
    logic [PART_W-1:0] part;
    logic [QUOT_W-1:0] extra;

    always_comb
    begin
        part  = PART_W'(dividend) * PART_W'(EXCESS);
        extra = '0;
        for (int j = 1; j <= EXCESS; j++)
        begin
            if (part >= PART_W'(j * DIVISOR))
            begin
                extra = extra + 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= start;
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            quot_reg <= QUOT_W'(dividend) + extra;
        end
    end

    assign done     = done_reg;
    assign quotient = quot_reg;

endmodule

/* src/chtr_cfg.sv */
// ----------------------------------------------------------------------------
// chtr_cfg
// Register port holding the search generation.
// ----------------------------------------------------------------------------
module chtr_cfg
    import chtr_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    output logic [4:0]  generation
);

    logic [4:0] generation_reg;
    logic       wr_gen;

    assign pready = 1'b1;
    assign wr_gen = psel && penable && pwrite && (paddr[2] == REG_GENERATION);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            generation_reg <= '0;
        end
        else if (wr_gen)
        begin
            generation_reg <= pwdata[4:0];
        end
    end

    always_comb
    begin
        unique case (paddr[2])
            REG_GENERATION: prdata = {27'd0, generation_reg};
            default:        prdata = 32'd0;
        endcase
    end

    assign generation = generation_reg;

endmodule

/* src/clustered_hash_table_replace.sv */
// ----------------------------------------------------------------------------
// clustered_hash_table_replace
// Clustered hash table with depth/age replacement, probe/store/hashfull/clear.
// ----------------------------------------------------------------------------
// A probe or store reads the cluster row from the cluster memory on the cycle
// the request is taken; the update state then picks the way, updates it, writes
// the row back and loads the result register once the output register is free.
// Hashfull takes the request, does one memory read per cluster, counts the
// last row, runs the permill scaling through the multiply and divide states and
// then loads the result register. Clear writes one row per cycle. After reset
// the same clearing pass runs before the first request is taken; register
// writes are taken throughout. A finished result waits in the output register
// while the next request is taken.
// ----------------------------------------------------------------------------
module clustered_hash_table_replace
    import chtr_pkg::*;
#(
    parameter int CLUSTER_BITS = 16,
    parameter int WAYS         = 3,
    parameter int DEPTH_BIAS   = 7
) (
    input  logic           clk,
    input  logic           rst_n,
    chtr_cmd_if.sink       cmd,
    chtr_result_if.source  res,
    input  logic           psel,
    input  logic           penable,
    input  logic           pwrite,
    input  logic [2:0]     paddr,
    input  logic [31:0]    pwdata,
    output logic [31:0]    prdata,
    output logic           pready
);

    localparam int ADDR_W      = CLUSTER_BITS;
    localparam int HF_CLUSTERS = 1000 / WAYS;
    localparam int HF_TOTAL    = WAYS * HF_CLUSTERS;
    localparam int HF_IDX_W    = $clog2(HF_CLUSTERS);
    localparam int CNT_W       = $clog2(HF_TOTAL + 1);
    localparam int ROW_CNT_W   = $clog2(WAYS + 1);
    localparam logic [HF_IDX_W-1:0] HF_LAST = HF_IDX_W'(HF_CLUSTERS - 1);

    state_t              state_reg;
    state_t              state_next;
    logic [4:0]          generation;
    logic [7:0]          gen8;

    req_t                req_reg;
    logic [ADDR_W-1:0]   idx_reg;
    logic [ADDR_W-1:0]   row_idx_reg;
    logic [HF_IDX_W-1:0] hf_idx_reg;
    logic                hf_acc_reg;
    logic [CNT_W-1:0]    cnt_reg;

    logic                cmd_accept;
    logic                out_free;
    logic                out_load;

    logic                rd_en;
    logic [ADDR_W-1:0]   rd_addr;
    entry_t [WAYS-1:0]   rd_data;
    logic                wr_en;
    logic [ADDR_W-1:0]   wr_addr;
    entry_t [WAYS-1:0]   wr_data;
    entry_t [WAYS-1:0]   row_new;
    sel_out_t            sel_out;

    logic [ROW_CNT_W-1:0] row_cnt;
    logic                div_start;
    logic                div_done;
    logic [9:0]          div_quot;

    logic                out_valid_reg;
    logic                out_hit_reg;
    logic [15:0]         out_move_reg;
    logic [15:0]         out_value_reg;
    logic [15:0]         out_eval_reg;
    logic [8:0]          out_depth_reg;
    logic [1:0]          out_bound_reg;
    logic                out_pv_reg;
    logic [9:0]          out_permill_reg;
    logic                out_hit_next;
    logic [15:0]         out_move_next;
    logic [15:0]         out_value_next;
    logic [15:0]         out_eval_next;
    logic [8:0]          out_depth_next;
    logic [1:0]          out_bound_next;
    logic                out_pv_next;
    logic [9:0]          out_permill_next;

    chtr_cfg u_cfg (
        .clk        (clk),
        .rst_n      (rst_n),
        .psel       (psel),
        .penable    (penable),
        .pwrite     (pwrite),
        .paddr      (paddr),
        .pwdata     (pwdata),
        .prdata     (prdata),
        .pready     (pready),
        .generation (generation)
    );

    assign gen8 = {generation, 3'b000};

    chtr_mem #(
        .ADDR_W (ADDR_W),
        .WAYS   (WAYS)
    ) u_mem (
        .clk     (clk),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_data),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data)
    );

    chtr_way_sel #(
        .WAYS       (WAYS),
        .DEPTH_BIAS (DEPTH_BIAS)
    ) u_way_sel (
        .row     (rd_data),
        .req     (req_reg),
        .gen8    (gen8),
        .row_new (row_new),
        .sel_out (sel_out)
    );

    chtr_div #(
        .DIVISOR    (HF_TOTAL),
        .SCALE      (HF_SCALE),
        .DIVIDEND_W (CNT_W),
        .QUOT_W     (10)
    ) u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (cnt_reg),
        .done     (div_done),
        .quotient (div_quot)
    );

    assign cmd_accept = cmd.valid && cmd.ready;
    assign out_free   = !out_valid_reg || res.ready;

    // current-generation entries in the row read during the hashfull scan
    always_comb
    begin
        row_cnt = '0;
        for (int i = 0; i < WAYS; i++)
        begin
            if ((rd_data[i].gen & AGE_MASK) == gen8)
            begin
                row_cnt = row_cnt + 1'b1;
            end
        end
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_INIT:
            begin
                if (row_idx_reg == '1)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                if (cmd.valid)
                begin
                    unique case (cmd_t'(cmd.command))
                        CMD_PROBE, CMD_STORE: state_next = ST_EVAL;
                        CMD_HASHFULL:         state_next = ST_HF_SCAN;
                        CMD_CLEAR:            state_next = ST_CLEAR;
                        default:              state_next = ST_IDLE;
                    endcase
                end
            end
            ST_EVAL:
            begin
                if (out_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_HF_SCAN:
            begin
                if (hf_idx_reg == HF_LAST)
                begin
                    state_next = ST_HF_LAST;
                end
            end
            ST_HF_LAST: state_next = ST_HF_MUL;
            ST_HF_MUL:  state_next = ST_HF_DIV;
            ST_HF_DIV:
            begin
                if (div_done)
                begin
                    state_next = ST_HF_OUT;
                end
            end
            ST_HF_OUT:
            begin
                if (out_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_CLEAR:
            begin
                if (row_idx_reg == '1)
                begin
                    state_next = ST_CLR_OUT;
                end
            end
            ST_CLR_OUT:
            begin
                if (out_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_INIT;
        endcase
    end

    // state outputs
    always_comb
    begin
        cmd.ready        = 1'b0;
        rd_en            = 1'b0;
        rd_addr          = cmd.key[31 -: ADDR_W];
        wr_en            = 1'b0;
        wr_addr          = row_idx_reg;
        wr_data          = '0;
        div_start        = 1'b0;
        out_load         = 1'b0;
        out_hit_next     = 1'b0;
        out_move_next    = '0;
        out_value_next   = '0;
        out_eval_next    = '0;
        out_depth_next   = '0;
        out_bound_next   = '0;
        out_pv_next      = 1'b0;
        out_permill_next = '0;
        unique case (state_reg)
            ST_INIT, ST_CLEAR:
            begin
                wr_en = 1'b1;
            end
            ST_IDLE:
            begin
                cmd.ready = 1'b1;
                rd_en     = cmd.valid;
            end
            ST_EVAL:
            begin
                wr_en          = out_free;
                wr_addr        = idx_reg;
                wr_data        = row_new;
                out_load       = out_free;
                out_hit_next   = sel_out.hit;
                out_move_next  = sel_out.ent.move;
                out_value_next = sel_out.ent.value;
                out_eval_next  = sel_out.ent.eval;
                out_depth_next = 9'({1'b0, sel_out.ent.depth} - 9'(DEPTH_BIAS));
                out_bound_next = sel_out.ent.gen[1:0];
                out_pv_next    = sel_out.ent.gen[2];
            end
            ST_HF_SCAN:
            begin
                rd_en   = 1'b1;
                rd_addr = ADDR_W'(hf_idx_reg);
            end
            ST_HF_MUL:
            begin
                div_start = 1'b1;
            end
            ST_HF_OUT:
            begin
                out_load         = out_free;
                out_permill_next = div_quot;
            end
            ST_CLR_OUT:
            begin
                out_load = out_free;
            end
            default:
            begin
                out_load = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_INIT;
            row_idx_reg   <= '0;
            hf_idx_reg    <= '0;
            hf_acc_reg    <= 1'b0;
            cnt_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            hf_acc_reg <= (state_reg == ST_HF_SCAN);
            if ((state_reg == ST_INIT) || (state_reg == ST_CLEAR))
            begin
                row_idx_reg <= row_idx_reg + 1'b1;
            end
            if (cmd_accept)
            begin
                hf_idx_reg <= '0;
                cnt_reg    <= '0;
            end
            else
            begin
                if (state_reg == ST_HF_SCAN)
                begin
                    hf_idx_reg <= hf_idx_reg + 1'b1;
                end
                if (hf_acc_reg)
                begin
                    cnt_reg <= cnt_reg + CNT_W'(row_cnt);
                end
            end
            if (out_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (res.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // request fields for the update cycle
    always_ff @(posedge clk)
    begin
        if (cmd_accept)
        begin
            req_reg.is_store <= (cmd_t'(cmd.command) == CMD_STORE);
            req_reg.tag      <= cmd.key[TAG_LSB +: 16];
            req_reg.value    <= cmd.new_value;
            req_reg.eval     <= cmd.new_eval;
            req_reg.pv       <= cmd.new_pv;
            req_reg.bound    <= cmd.new_bound;
            req_reg.depth    <= cmd.new_depth;
            req_reg.move     <= cmd.new_move;
            idx_reg          <= cmd.key[31 -: ADDR_W];
        end
    end

    always_ff @(posedge clk)
    begin
        if (out_load)
        begin
            out_hit_reg     <= out_hit_next;
            out_move_reg    <= out_move_next;
            out_value_reg   <= out_value_next;
            out_eval_reg    <= out_eval_next;
            out_depth_reg   <= out_depth_next;
            out_bound_reg   <= out_bound_next;
            out_pv_reg      <= out_pv_next;
            out_permill_reg <= out_permill_next;
        end
    end

    assign res.valid        = out_valid_reg;
    assign res.hit          = out_hit_reg;
    assign res.stored_move  = out_move_reg;
    assign res.stored_value = $signed(out_value_reg);
    assign res.stored_eval  = $signed(out_eval_reg);
    assign res.stored_depth = $signed(out_depth_reg);
    assign res.stored_bound = out_bound_reg;
    assign res.stored_pv    = out_pv_reg;
    assign res.permill_full = out_permill_reg;

endmodule
